FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the polygon cell tester.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/pet_pkg.sv
// Package for the polygon cell tester: sizes, register codes, states, types.
// Depends on nothing; imported by every module of the block.
package pet_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int GRID_W       = 256;
    localparam int GRID_H       = 256;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 2 * MUL_W;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;

    typedef enum logic [2:0] {
        CFG_OFFSET_X  = 3'd0,
        CFG_OFFSET_Y  = 3'd1,
        CFG_INV_SCALE = 3'd2,
        CFG_PIVOT_X   = 3'd3,
        CFG_PIVOT_Y   = 3'd4,
        CFG_COSINE    = 3'd5,
        CFG_SINE      = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAPX,
        S_MAPY,
        S_MAPW,
        S_DIFF,
        S_ROT1,
        S_ROT2,
        S_ROT3,
        S_ROT4,
        S_ROT5,
        S_ROT6,
        S_LDPREV,
        S_LDCUR,
        S_EDGE0,
        S_EDGE1,
        S_EDGE2,
        S_EDGE3,
        S_NEXT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } t_vertex;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sh7FFF_FFFF);
        lo = -PROD_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/pet_vstore.sv
// Vertex memory: one write port, one registered read port.
// Depends on pet_pkg.
module pet_vstore (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [pet_pkg::ADDR_W-1:0] i_waddr,
    input  pet_pkg::t_vertex          i_wdata,
    input  logic [pet_pkg::ADDR_W-1:0] i_raddr,
    output pet_pkg::t_vertex          o_rdata
);
    import pet_pkg::*;

    t_vertex r_mem [MAX_VERTICES];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/pet_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pet_pkg.
module pet_mul (
    input  logic                              i_clk,
    input  logic signed [pet_pkg::MUL_W-1:0]  i_a,
    input  logic signed [pet_pkg::MUL_W-1:0]  i_b,
    output logic signed [pet_pkg::PROD_W-1:0] o_p
);
    import pet_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

FILE: rtl/polygon_even_odd_cell_test.sv
// Top level of the polygon cell tester: sequencer, registers, datapath.
// Depends on pet_pkg, pet_vstore, pet_mul and assert_macros.svh.
//
//   channel   direction  handshake                 payload
//   request   in         i_valid / o_ready         req_type restart vertex_x/y cell_x/y
//   result    out        o_valid / i_ready         inside_res overflowed
//   config    in         i_cfg_valid / o_cfg_ready cfg_index cfg_data
//
// An append gives no result.
// A test maps and rotates the cell point, then reads each edge; only an edge that the
// cell row crosses goes on to the products, all on one shared multiplier.
// Fewer than three vertices or a cell off the grid goes straight to the result.
// A result waits in the output register; the next item is taken meanwhile.
// Reset is synchronous; the vertex memory is not cleared.
module polygon_even_odd_cell_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic        i_restart,
    input  logic [31:0] i_vertex_x,
    input  logic [31:0] i_vertex_y,
    input  logic [7:0]  i_cell_x,
    input  logic [7:0]  i_cell_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_inside_res,
    output logic        o_overflowed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pet_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_total, n_total, r_idx, n_idx;
    logic r_ovf, n_ovf, r_inside, n_inside, r_cross, n_cross;
    logic r_ovalid, n_ovalid, r_oin, n_oin, r_oovf, n_oovf;
    logic [7:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [PROD_W-1:0] r_acc, n_acc, r_p1, n_p1;
    logic signed [31:0] r_wx, n_wx, r_wy, n_wy, r_lx, n_lx, r_ly, n_ly;
    logic signed [32:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [32:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    t_vertex r_prev, n_prev, r_cur, n_cur;

    logic signed [31:0] r_off_x, r_off_y, r_piv_x, r_piv_y, r_cos, r_sin;
    logic [31:0] r_scale;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    t_vertex mem_rdata, mem_wdata;

    logic signed [33:0] g_x, g_y;
    logic signed [31:0] cos_c, sin_c;
    logic signed [31:0] xi, yi, xj, yj;

    pet_vstore u_vstore (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pet_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid      = r_ovalid;
    assign o_inside_res = r_oin;
    assign o_overflowed = r_oovf;

    assign g_x = $signed({10'd0, r_cx, 16'd0}) - $signed({{2{r_off_x[31]}}, r_off_x});
    assign g_y = $signed({10'd0, r_cy, 16'd0}) - $signed({{2{r_off_y[31]}}, r_off_y});
    assign cos_c = (r_cos > ONE_Q30) ? ONE_Q30 : ((r_cos < NEG_ONE_Q30) ? NEG_ONE_Q30 : r_cos);
    assign sin_c = (r_sin > ONE_Q30) ? ONE_Q30 : ((r_sin < NEG_ONE_Q30) ? NEG_ONE_Q30 : r_sin);
    assign xi = $signed(r_cur.x);
    assign yi = $signed(r_cur.y);
    assign xj = $signed(r_prev.x);
    assign yj = $signed(r_prev.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_scale <= 32'd65536;
            r_piv_x <= '0;
            r_piv_y <= '0;
            r_cos   <= ONE_Q30;
            r_sin   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_X:  r_off_x <= $signed(i_cfg_data);
                CFG_OFFSET_Y:  r_off_y <= $signed(i_cfg_data);
                CFG_INV_SCALE: r_scale <= i_cfg_data;
                CFG_PIVOT_X:   r_piv_x <= $signed(i_cfg_data);
                CFG_PIVOT_Y:   r_piv_y <= $signed(i_cfg_data);
                CFG_COSINE:    r_cos   <= $signed(i_cfg_data);
                CFG_SINE:      r_sin   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_idx    = r_idx;
        n_ovf    = r_ovf;
        n_inside = r_inside;
        n_cross  = r_cross;
        n_ovalid = r_ovalid;
        n_oin    = r_oin;
        n_oovf   = r_oovf;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_acc    = r_acc;
        n_p1     = r_p1;
        n_wx     = r_wx;
        n_wy     = r_wy;
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_prev   = r_prev;
        n_cur    = r_cur;
        mul_a    = g_x;
        mul_b    = $signed({2'b00, r_scale});
        mem_we   = 1'b0;
        mem_waddr = r_total[ADDR_W-1:0];
        mem_wdata = '{x: i_vertex_x, y: i_vertex_y};
        mem_raddr = r_idx[ADDR_W-1:0];

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_req_type) begin
                        if (i_restart) begin
                            n_ovf     = 1'b0;
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            n_total   = CNT_W'(1);
                        end else if (r_total < CNT_W'(MAX_VERTICES)) begin
                            mem_we  = 1'b1;
                            n_total = r_total + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_cx     = i_cell_x;
                        n_cy     = i_cell_y;
                        n_inside = 1'b0;
                        if ((17'(i_cell_x) < 17'(GRID_W)) && (17'(i_cell_y) < 17'(GRID_H))
                            && (r_total >= CNT_W'(3))) begin
                            n_state = S_MAPX;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_MAPX: begin
                mul_a   = g_x;
                n_state = S_MAPY;
            end
            S_MAPY: begin
                mul_a   = g_y;
                n_wx    = sat32(mul_p >>> 16);
                n_state = S_MAPW;
            end
            S_MAPW: begin
                n_wy    = sat32(mul_p >>> 16);
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_dx    = $signed({r_wx[31], r_wx}) - $signed({r_piv_x[31], r_piv_x});
                n_dy    = $signed({r_wy[31], r_wy}) - $signed({r_piv_y[31], r_piv_y});
                n_state = S_ROT1;
            end
            S_ROT1: begin
                mul_a   = {r_dx[32], r_dx};
                mul_b   = {{2{cos_c[31]}}, cos_c};
                n_state = S_ROT2;
            end
            S_ROT2: begin
                n_acc   = mul_p;
                mul_a   = {r_dy[32], r_dy};
                mul_b   = {{2{sin_c[31]}}, sin_c};
                n_state = S_ROT3;
            end
            S_ROT3: begin
                n_acc   = r_acc + mul_p;
                mul_a   = {r_dy[32], r_dy};
                mul_b   = {{2{cos_c[31]}}, cos_c};
                n_state = S_ROT4;
            end
            S_ROT4: begin
                n_lx    = sat32((r_acc >>> 30) + $signed({{(PROD_W-32){r_piv_x[31]}}, r_piv_x}));
                n_acc   = mul_p;
                mul_a   = {r_dx[32], r_dx};
                mul_b   = {{2{sin_c[31]}}, sin_c};
                n_state = S_ROT5;
            end
            S_ROT5: begin
                n_acc   = r_acc - mul_p;
                n_state = S_ROT6;
            end
            S_ROT6: begin
                n_ly      = sat32((r_acc >>> 30) + $signed({{(PROD_W-32){r_piv_y[31]}}, r_piv_y}));
                mem_raddr = ADDR_W'(r_total - CNT_W'(1));
                n_state   = S_LDPREV;
            end
            S_LDPREV: begin
                n_prev    = mem_rdata;
                n_idx     = '0;
                mem_raddr = '0;
                n_state   = S_LDCUR;
            end
            S_LDCUR: begin
                n_cur   = mem_rdata;
                n_state = S_EDGE0;
            end
            S_EDGE0: begin
                n_cross = (yi > r_ly) != (yj > r_ly);
                n_a     = $signed({r_lx[31], r_lx}) - $signed({xi[31], xi});
                n_b     = $signed({yj[31], yj}) - $signed({yi[31], yi});
                n_c     = $signed({xj[31], xj}) - $signed({xi[31], xi});
                n_d     = $signed({r_ly[31], r_ly}) - $signed({yi[31], yi});
                n_state = S_EDGE1;
            end
            S_EDGE1: begin
                mul_a   = {r_a[32], r_a};
                mul_b   = {r_b[32], r_b};
                n_state = r_cross ? S_EDGE2 : S_NEXT;
            end
            S_EDGE2: begin
                n_p1    = mul_p;
                mul_a   = {r_c[32], r_c};
                mul_b   = {r_d[32], r_d};
                n_state = S_EDGE3;
            end
            S_EDGE3: begin
                if ((!r_b[32] && (r_b != '0) && (r_p1 < mul_p))
                    || (r_b[32] && (r_p1 > mul_p))) begin
                    n_inside = !r_inside;
                end
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_prev    = r_cur;
                n_idx     = r_idx + CNT_W'(1);
                mem_raddr = n_idx[ADDR_W-1:0];
                n_state   = (n_idx == r_total) ? S_OUT : S_LDCUR;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oin    = r_inside;
                    n_oovf   = r_ovf;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_idx    <= '0;
            r_ovf    <= 1'b0;
            r_inside <= 1'b0;
            r_cross  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_idx    <= n_idx;
            r_ovf    <= n_ovf;
            r_inside <= n_inside;
            r_cross  <= n_cross;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oin  <= n_oin;
        r_oovf <= n_oovf;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_acc  <= n_acc;
        r_p1   <= n_p1;
        r_wx   <= n_wx;
        r_wy   <= n_wy;
        r_lx   <= n_lx;
        r_ly   <= n_ly;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_prev <= n_prev;
        r_cur  <= n_cur;
    end

    `ASSERT_ALWAYS(a_total_cap, i_clk, i_rst_n, r_total <= CNT_W'(MAX_VERTICES))
    `ASSERT_IMPLIES(a_ovf_full, i_clk, i_rst_n, r_ovf, r_total == CNT_W'(MAX_VERTICES))
    `ASSERT_IMPLIES(a_idx_range, i_clk, i_rst_n, r_state == S_LDCUR, r_idx < r_total)
endmodule

FILE: tb/sv/tb_polygon_even_odd_cell_test.sv
`timescale 1ns / 1ps
// Self-checking bench for polygon_even_odd_cell_test: queued items, bursty driver, stalling
// result monitor and an even-odd predictor. Depends on pet_pkg and the RTL.
module tb_polygon_even_odd_cell_test;
    import pet_pkg::*;

    localparam bit REQ_APPEND = 1'b0;
    localparam bit REQ_TEST   = 1'b1;
    localparam int IDLE_LIMIT = 60000;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        bit          kind;
        bit          restart;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [7:0]  cx;
        logic [7:0]  cy;
    } t_item;

    typedef struct {
        bit in_poly;
        bit ovf;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        o_ready;
    logic        req_type = 1'b0;
    logic        req_restart = 1'b0;
    logic [31:0] req_vx = '0;
    logic [31:0] req_vy = '0;
    logic [7:0]  req_cx = '0;
    logic [7:0]  req_cy = '0;
    logic        o_valid;
    logic        res_ready = 1'b0;
    logic        o_inside_res;
    logic        o_overflowed;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      error_count = 0;
    int      results_seen = 0;

    // shadow of the block's registers and vertex list
    logic signed [31:0] sh_off_x = 0, sh_off_y = 0, sh_piv_x = 0, sh_piv_y = 0;
    logic signed [31:0] sh_cos = ONE_Q30, sh_sin = 0;
    logic        [31:0] sh_scale = 32'h0001_0000;
    logic signed [31:0] poly_x[MAX_VERTICES];
    logic signed [31:0] poly_y[MAX_VERTICES];
    int                 poly_count = 0;
    bit                 poly_ovf = 1'b0;

    always #10 i_clk = ~i_clk;

    polygon_even_odd_cell_test u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(req_valid), .o_ready(o_ready),
        .i_req_type(req_type), .i_restart(req_restart),
        .i_vertex_x(req_vx), .i_vertex_y(req_vy),
        .i_cell_x(req_cx), .i_cell_y(req_cy),
        .o_valid(o_valid), .i_ready(res_ready),
        .o_inside_res(o_inside_res), .o_overflowed(o_overflowed),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic logic signed [31:0] clip32(input logic signed [99:0] v);
        if (v > 100'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -100'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] cell_to_world(input logic [7:0] grid_pos,
                                                         input logic signed [31:0] off);
        logic signed [39:0] g;
        logic        [39:0] mag;
        logic        [79:0] full;
        logic        [63:0] p;
        logic        [63:0] q;
        logic signed [99:0] v;
        g = $signed({16'd0, grid_pos, 16'd0}) - off;
        mag = g[39] ? -g : g;
        full = mag * {8'd0, sh_scale};
        p = full[63:0];
        q = p >> 16;
        if (g[39] && p[15:0] != 0) q = q + 1;
        v = $signed({36'd0, q});
        if (g[39]) v = -v;
        return clip32(v);
    endfunction

    function automatic logic signed [31:0] limit_unit(input logic signed [31:0] v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < NEG_ONE_Q30) return NEG_ONE_Q30;
        return v;
    endfunction

    function automatic bit crossing_parity(input logic signed [31:0] px,
                                           input logic signed [31:0] py);
        bit                 odd;
        int                 j;
        logic signed [39:0] xi, yi, xj, yj, dyv;
        logic signed [79:0] lhs, rhs;
        odd = 1'b0;
        if (poly_count < 3) return 1'b0;
        j = poly_count - 1;
        for (int i = 0; i < poly_count; i++) begin
            xi = poly_x[i]; yi = poly_y[i]; xj = poly_x[j]; yj = poly_y[j];
            if ((yi > py) != (yj > py)) begin
                dyv = yj - yi;
                lhs = (px - xi) * dyv;
                rhs = (xj - xi) * (py - yi);
                if ((dyv > 0 && lhs < rhs) || (dyv < 0 && lhs > rhs)) odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    task automatic apply_item(input t_item it);
        logic signed [39:0] dx, dy;
        logic signed [39:0] c, s;
        logic signed [99:0] rx, ry;
        t_answer            ans;
        if (it.kind == REQ_APPEND) begin
            if (it.restart) begin
                poly_count = 0;
                poly_ovf = 1'b0;
            end
            if (poly_count < MAX_VERTICES) begin
                poly_x[poly_count] = it.vx;
                poly_y[poly_count] = it.vy;
                poly_count++;
            end else begin
                poly_ovf = 1'b1;
            end
        end else begin
            dx = cell_to_world(it.cx, sh_off_x) - sh_piv_x;
            dy = cell_to_world(it.cy, sh_off_y) - sh_piv_y;
            c = limit_unit(sh_cos);
            s = limit_unit(sh_sin);
            rx = ((dx * c + dy * s) >>> 30) + sh_piv_x;
            ry = ((dy * c - dx * s) >>> 30) + sh_piv_y;
            ans.in_poly = crossing_parity(clip32(rx), clip32(ry));
            ans.ovf = poly_ovf;
            expected_answers.push_back(ans);
        end
    endtask

    // driver
    int    burst_left = 1;
    int    gap_left = 0;
    t_item cur_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && o_ready) apply_item(cur_item);
            if (!req_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    req_valid <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    req_valid <= 1'b1;
                    req_type <= cur_item.kind;
                    req_restart <= cur_item.restart;
                    req_vx <= cur_item.vx;
                    req_vy <= cur_item.vy;
                    req_cx <= cur_item.cx;
                    req_cy <= cur_item.cy;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // monitor
    int stall_hold = 0;
    bit stall_done = 1'b0;
    int pattern_cnt = 0;
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (o_valid && res_ready) begin
                results_seen++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected item: inside_res=%0b overflowed=%0b",
                           o_inside_res, o_overflowed);
                    error_count++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (o_inside_res !== exp_ans.in_poly) begin
                        $error("inside_res: expected %0b, got %0b", exp_ans.in_poly, o_inside_res);
                        error_count++;
                    end
                    if (o_overflowed !== exp_ans.ovf) begin
                        $error("overflowed: expected %0b, got %0b", exp_ans.ovf, o_overflowed);
                        error_count++;
                    end
                end
            end
            pattern_cnt++;
            if (stall_hold > 0) begin
                stall_hold--;
                res_ready <= 1'b0;
            end else if (results_seen >= 40 && !stall_done) begin
                stall_done = 1'b1;
                stall_hold = 800;
                res_ready <= 1'b0;
            end else if (pattern_cnt[7]) begin
                res_ready <= 1'b1;
            end else begin
                res_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_valid && o_ready) || (o_valid && res_ready) || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_regs(input logic [31:0] vals[7]);
        t_cfg_idx idx;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 7; i++) begin
            idx = t_cfg_idx'(i);
            cfg_index <= idx;
            cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_OFFSET_X:  sh_off_x = vals[i];
                CFG_OFFSET_Y:  sh_off_y = vals[i];
                CFG_INV_SCALE: sh_scale = vals[i];
                CFG_PIVOT_X:   sh_piv_x = vals[i];
                CFG_PIVOT_Y:   sh_piv_y = vals[i];
                CFG_COSINE:    sh_cos = vals[i];
                CFG_SINE:      sh_sin = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_vertex(input bit rst, input logic [31:0] x, input logic [31:0] y);
        t_item it;
        it = '{REQ_APPEND, rst, x, y, 8'($urandom), 8'($urandom)};
        pending_items.push_back(it);
    endtask

    task automatic add_probe(input logic [7:0] x, input logic [7:0] y);
        t_item it;
        it = '{REQ_TEST, 1'($urandom), $urandom, $urandom, x, y};
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_coord(input bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 32'h0100_0000) - $urandom_range(0, 32'h0004_0000);
    endfunction

    task automatic fill_random(input int budget, input bit wide);
        int n;
        int k;
        while (budget > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                if ($urandom_range(0, 40) == 0) n = $urandom_range(30, 60);
                add_vertex(1'b1, pick_coord(wide), pick_coord(wide));
                for (int i = 1; i < n; i++) add_vertex(1'b0, pick_coord(wide), pick_coord(wide));
                k = $urandom_range(2, 8);
                for (int i = 0; i < k; i++) add_probe($urandom, $urandom);
                budget -= n + k;
            end else begin
                if ($urandom_range(0, 1)) add_vertex(1'b0, $urandom, $urandom);
                else add_probe($urandom, $urandom);
                budget--;
            end
        end
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || req_valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] regs[7];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: cell maps straight to world
        regs = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h4000_0000, 32'h0};
        write_regs(regs);
        add_probe(8'd5, 8'd5);
        add_vertex(1'b1, 32'h0, 32'h0);
        add_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_probe(8'd0, 8'd0);
        add_vertex(1'b1, 32'h0, 32'h0);
        add_vertex(1'b0, 32'h00C8_0000, 32'h0);
        add_vertex(1'b0, 32'h0, 32'h00C8_0000);
        add_probe(8'd10, 8'd10);
        add_probe(8'd150, 8'd150);
        add_probe(8'd0, 8'd0);
        add_probe(8'd100, 8'd0);
        add_probe(8'd255, 8'd255);
        add_vertex(1'b1, 32'h8000_0000, 32'h8000_0000);
        add_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vertex(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_probe(8'd0, 8'd0);
        add_probe(8'd255, 8'd255);
        // overrun the vertex store
        add_vertex(1'b1, pick_coord(0), pick_coord(0));
        for (int i = 1; i < MAX_VERTICES + 4; i++) add_vertex(1'b0, pick_coord(0), pick_coord(0));
        add_probe($urandom, $urandom);
        add_probe($urandom, $urandom);
        add_vertex(1'b0, 32'h0, 32'h0);
        add_probe($urandom, $urandom);
        fill_random(250, 1'b0);
        settle();

        // quarter turn about the grid center
        regs = '{32'h0, 32'h0, 32'h0001_0000, 32'h0080_0000, 32'h0080_0000, 32'h0, 32'h4000_0000};
        write_regs(regs);
        fill_random(270, 1'b0);
        settle();

        // extremes, cosine and sine beyond unity
        regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_regs(regs);
        fill_random(200, 1'b1);
        settle();

        // zero scale: every cell lands on the origin
        regs = '{$urandom, $urandom, 32'h0, 32'h0, 32'h0, 32'hC000_0000, 32'h0};
        write_regs(regs);
        fill_random(150, 1'b0);
        settle();

        // shifted, doubled, eighth turn
        regs = '{32'h0040_0000, 32'h0020_0000, 32'h0000_8000, 32'h0080_0000,
                 32'h0080_0000, 32'h2D41_3CCD, 32'hD2BE_C333};
        write_regs(regs);
        fill_random(250, 1'b0);
        settle();

        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: polygon_even_odd_cell_test.f
+incdir+rtl
rtl/pet_pkg.sv
rtl/pet_vstore.sv
rtl/pet_mul.sv
rtl/polygon_even_odd_cell_test.sv
tb/sv/tb_polygon_even_odd_cell_test.sv
